/* design/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the console cell writer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, ignored while reset is low.
`define TCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Check a property on the rising clock edge, reset cycles included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* design/tcw_pkg.sv */
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, codes and character constants for the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int ROWS_DEF   = 25;
    localparam int COLS_DEF   = 80;
    localparam int QDEPTH     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam int CELL_W     = 16;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_HEX   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_FG = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BG = CFG_IDX_W'(1);

    localparam logic [3:0] FG_RESET = 4'hF;
    localparam logic [3:0] BG_RESET = 4'h0;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_BLANK = 8'h00;

    localparam logic [3:0] HEX_LAST = 4'd9;

    typedef struct packed {
        logic [1:0]  op;
        logic [7:0]  ch;
        logic [31:0] hex_word;
        logic [10:0] cell_addr;
    } t_in;

    typedef struct packed {
        logic [10:0] cursor;
        logic [15:0] cell_data;
        logic        scrolled;
    } t_out;

    typedef struct packed {
        logic [1:0]  op;
        logic        in_range;
        logic [7:0]  ch;
        logic [31:0] hex_word;
        logic [10:0] cell_addr;
    } t_cmd;

    typedef struct packed {
        logic init_busy;
    } t_back_stat;

    function automatic logic [7:0] hex_char(input logic [3:0] nib);
        logic [7:0] c;
        case (nib)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'hA: c = 8'h61;
            4'hB: c = 8'h62;
            4'hC: c = 8'h63;
            4'hD: c = 8'h64;
            4'hE: c = 8'h65;
            default: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

/* design/tcw_ram.sv */
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tcw_front.sv */
// ----------------------------------------------------------------------------
// tcw_front
// Intake: classify each item and hold it in a short command queue.
// ----------------------------------------------------------------------------
module tcw_front #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  tcw_pkg::t_in        i_item,
    input  tcw_pkg::t_back_stat i_stat,
    output logic                o_cmd_valid,
    output tcw_pkg::t_cmd       o_cmd,
    input  logic                i_cmd_take
);

    localparam int NCELLS = ROWS * COLS;
    localparam int QD     = tcw_pkg::QDEPTH;
    localparam int QAW    = (QD > 1) ? $clog2(QD) : 1;
    localparam int QCW    = $clog2(QD + 1);

    tcw_pkg::t_cmd  r_q [QD];
    logic [QAW-1:0] r_wr_ptr, n_wr_ptr;
    logic [QAW-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCW-1:0] r_cnt, n_cnt;
    tcw_pkg::t_cmd  cmd_in;
    logic           do_push;
    logic           do_pop;

    // Tag reads that fall outside the store so the back end returns zero.
    always_comb begin
        cmd_in.op        = i_item.op;
        cmd_in.in_range  = (32'(i_item.cell_addr) < NCELLS);
        cmd_in.ch        = i_item.ch;
        cmd_in.hex_word  = i_item.hex_word;
        cmd_in.cell_addr = i_item.cell_addr;
    end

    assign o_full      = (r_cnt == QCW'(QD)) || i_stat.init_busy;
    assign do_push     = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != '0);
    assign do_pop      = i_cmd_take && o_cmd_valid;
    assign o_cmd       = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_cnt    = r_cnt;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QAW'(QD - 1)) ? '0 : r_wr_ptr + QAW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QAW'(QD - 1)) ? '0 : r_rd_ptr + QAW'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + QCW'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - QCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

/* design/tcw_back.sv */
// ----------------------------------------------------------------------------
// tcw_back
// Execution: cell writes, scrolls, clears and reads on the cell store.
// ----------------------------------------------------------------------------
module tcw_back #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cmd_valid,
    input  tcw_pkg::t_cmd       i_cmd,
    output logic                o_cmd_take,
    output tcw_pkg::t_back_stat o_stat,
    input  logic [3:0]          i_fg,
    input  logic [3:0]          i_bg,
    output logic                o_res_valid,
    output tcw_pkg::t_out       o_res,
    input  logic                i_res_pop
);

    localparam int NCELLS = ROWS * COLS;
    localparam int AW     = $clog2(NCELLS);
    localparam int CW     = $clog2(NCELLS + 1);
    localparam int CELLW  = tcw_pkg::CELL_W;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PUT    = 3'd1;
    localparam logic [2:0] S_SCROLL = 3'd2;
    localparam logic [2:0] S_BLANK  = 3'd3;
    localparam logic [2:0] S_FILL   = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_DONE   = 3'd6;

    localparam logic [AW-1:0] IDX_LAST  = AW'(NCELLS - 1);
    localparam logic [AW-1:0] IDX_BOT   = AW'(NCELLS - COLS);
    localparam logic [AW-1:0] IDX_COLS  = AW'(COLS);
    localparam logic [CW-1:0] CUR_END   = CW'(NCELLS);
    localparam logic [CW-1:0] CUR_BOT   = CW'(NCELLS - COLS);

    logic [2:0]       r_state, n_state;
    logic [CW-1:0]    r_cursor, n_cursor;
    logic [AW-1:0]    r_idx, n_idx;
    logic             r_wpend, n_wpend;
    logic [AW-1:0]    r_waddr, n_waddr;
    logic             r_zero, n_zero;
    logic             r_hex, n_hex;
    logic [3:0]       r_nchar, n_nchar;
    logic [31:0]      r_word, n_word;
    logic [7:0]       r_char, n_char;
    logic             r_scr, n_scr;
    logic [15:0]      r_data, n_data;
    logic             r_in_range, n_in_range;
    logic             r_res_valid, n_res_valid;
    tcw_pkg::t_out    r_res, n_res;

    logic [7:0]       attr;
    logic [CELLW-1:0] blank;
    logic [7:0]       cur_char;
    logic             past_end;
    logic             slot_free;
    logic             we;
    logic [AW-1:0]    waddr;
    logic [CELLW-1:0] wdata;
    logic [AW-1:0]    raddr;
    logic [CELLW-1:0] rdata;

    assign attr      = {i_bg, i_fg};
    assign blank     = {attr, tcw_pkg::CH_BLANK};
    assign past_end  = (r_cursor >= CUR_END);
    assign slot_free = !r_res_valid || i_res_pop;

    always_comb begin
        if (!r_hex) begin
            cur_char = r_char;
        end else if (r_nchar == 4'd0) begin
            cur_char = tcw_pkg::CH_ZERO;
        end else if (r_nchar == 4'd1) begin
            cur_char = tcw_pkg::CH_X;
        end else begin
            cur_char = tcw_pkg::hex_char(r_word[31:28]);
        end
    end

    // Write port: a pending scroll copy always goes first.
    always_comb begin
        we    = 1'b0;
        waddr = r_idx;
        wdata = blank;
        if (r_wpend) begin
            we    = 1'b1;
            waddr = r_waddr;
            wdata = rdata;
        end else begin
            case (r_state)
                S_PUT: begin
                    we    = !past_end;
                    waddr = AW'(r_cursor);
                    wdata = {attr, cur_char};
                end
                S_BLANK: begin
                    we = 1'b1;
                end
                S_FILL: begin
                    we    = 1'b1;
                    wdata = r_zero ? '0 : blank;
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    assign raddr = (r_state == S_IDLE) ? AW'(i_cmd.cell_addr) : r_idx;

    assign o_cmd_take  = (r_state == S_IDLE) && i_cmd_valid;
    assign o_stat.init_busy = r_zero;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    always_comb begin
        n_state     = r_state;
        n_cursor    = r_cursor;
        n_idx       = r_idx;
        n_wpend     = 1'b0;
        n_waddr     = r_idx - IDX_COLS;
        n_zero      = r_zero;
        n_hex       = r_hex;
        n_nchar     = r_nchar;
        n_word      = r_word;
        n_char      = r_char;
        n_scr       = r_scr;
        n_data      = r_data;
        n_in_range  = r_in_range;
        n_res_valid = r_res_valid && !i_res_pop;
        n_res       = r_res;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_scr      = 1'b0;
                    n_data     = '0;
                    n_char     = i_cmd.ch;
                    n_word     = i_cmd.hex_word;
                    n_nchar    = '0;
                    n_in_range = i_cmd.in_range;
                    unique case (i_cmd.op)
                        tcw_pkg::OP_PUT: begin
                            n_hex   = 1'b0;
                            n_state = S_PUT;
                        end
                        tcw_pkg::OP_HEX: begin
                            n_hex   = 1'b1;
                            n_state = S_PUT;
                        end
                        tcw_pkg::OP_READ: begin
                            n_state = S_READ;
                        end
                        default: begin
                            n_idx    = '0;
                            n_cursor = '0;
                            n_state  = S_FILL;
                        end
                    endcase
                end
            end
            S_PUT: begin
                if (past_end) begin
                    // Start the scroll: copy every row below the top one row up.
                    n_scr   = 1'b1;
                    n_idx   = IDX_COLS;
                    n_state = S_SCROLL;
                end else begin
                    n_cursor = r_cursor + CW'(1);
                    if (r_hex && (r_nchar != tcw_pkg::HEX_LAST)) begin
                        n_nchar = r_nchar + 4'd1;
                        if (r_nchar >= 4'd2) begin
                            n_word = {r_word[27:0], 4'h0};
                        end
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SCROLL: begin
                n_wpend = 1'b1;
                if (r_idx == IDX_LAST) begin
                    n_idx   = IDX_BOT;
                    n_state = S_BLANK;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_BLANK: begin
                if (!r_wpend) begin
                    if (r_idx == IDX_LAST) begin
                        n_cursor = CUR_BOT;
                        n_state  = S_PUT;
                    end else begin
                        n_idx = r_idx + AW'(1);
                    end
                end
            end
            S_FILL: begin
                if (r_idx == IDX_LAST) begin
                    n_idx   = '0;
                    n_zero  = 1'b0;
                    n_state = r_zero ? S_IDLE : S_DONE;
                end else begin
                    n_idx = r_idx + AW'(1);
                end
            end
            S_READ: begin
                n_data  = r_in_range ? rdata : '0;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (slot_free) begin
                    n_res_valid        = 1'b1;
                    n_res.cursor       = 11'(r_cursor);
                    n_res.cell_data    = r_data;
                    n_res.scrolled     = r_scr;
                    n_state            = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_FILL;
            r_cursor    <= '0;
            r_idx       <= '0;
            r_wpend     <= 1'b0;
            r_zero      <= 1'b1;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cursor    <= n_cursor;
            r_idx       <= n_idx;
            r_wpend     <= n_wpend;
            r_zero      <= n_zero;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_waddr    <= n_waddr;
        r_hex      <= n_hex;
        r_nchar    <= n_nchar;
        r_word     <= n_word;
        r_char     <= n_char;
        r_scr      <= n_scr;
        r_data     <= n_data;
        r_in_range <= n_in_range;
        r_res      <= n_res;
    end

    tcw_ram #(
        .W     (CELLW),
        .DEPTH (NCELLS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

endmodule

/* design/text_console_cell_writer_core.sv */
// ----------------------------------------------------------------------------
// text_console_cell_writer_core
// The back end works on one item at a time.
// A put that finds the cursor past the end first scrolls the store, and a
// clear fills every cell; both stream through the single store write port.
// Reset: synchronous; a zeroing pass over every cell follows, full high.
// ----------------------------------------------------------------------------
module text_console_cell_writer_core #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // item intake
    input  logic                               push,
    output logic                               full,
    input  tcw_pkg::t_in                       i_item,
    // result output
    output logic                               empty,
    input  logic                               pop,
    output tcw_pkg::t_out                      o_result,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tcw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcw_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // Color registers; only the low nibble of a write is kept and an
    // index past the register list is dropped.
    logic [3:0] r_fg;
    logic [3:0] r_bg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg <= tcw_pkg::FG_RESET;
            r_bg <= tcw_pkg::BG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == tcw_pkg::CFG_FG) begin
                r_fg <= i_cfg_data[3:0];
            end else if (i_cfg_index == tcw_pkg::CFG_BG) begin
                r_bg <= i_cfg_data[3:0];
            end
        end
    end

    // Front to back: the command queue handshake and the back end status.
    logic                cmd_valid;
    tcw_pkg::t_cmd       cmd;
    logic                cmd_take;
    tcw_pkg::t_back_stat back_stat;
    logic                res_valid;

    // Front end: classify each transfer and hold it until the back end
    // is free. It keeps taking items while a result waits to be popped, until its queue fills.
    tcw_front #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .i_stat      (back_stat),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // Back end: one command at a time against the cell store. Scrolls
    // stream one cell per cycle; the result lands in an output register.
    tcw_back #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .o_stat      (back_stat),
        .i_fg        (r_fg),
        .i_bg        (r_bg),
        .o_res_valid (res_valid),
        .o_res       (o_result),
        .i_res_pop   (pop)
    );

    assign empty = !res_valid;

endmodule

/* design/tcw_checker.sv */
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks on the console cell writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker #(
    parameter int ROWS = tcw_pkg::ROWS_DEF,
    parameter int COLS = tcw_pkg::COLS_DEF
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          full,
    input logic          empty,
    input logic          pop,
    input tcw_pkg::t_out o_result
);

    localparam int  NCELLS  = ROWS * COLS;
    localparam int  BOT_ROW = NCELLS - COLS;
    localparam bit  NARROW  = (NCELLS < 2048);

    logic shown_narrow;
    logic scroll_shown;

    assign shown_narrow = !empty && NARROW;
    assign scroll_shown = shown_narrow && o_result.scrolled;

    `TCW_ASSERT(a_cursor_range, shown_narrow |-> o_result.cursor <= NCELLS, "cursor past end")
    `TCW_ASSERT(a_scroll_cursor, scroll_shown |-> o_result.cursor > BOT_ROW, "scroll cursor high")
    `TCW_ASSERT(a_result_hold, !empty && !pop |=> !empty && $stable(o_result), "result moved")
    `TCW_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> empty && full, "not quiet after reset")

endmodule

bind text_console_cell_writer_core tcw_checker #(
    .ROWS (ROWS),
    .COLS (COLS)
) u_tcw_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .o_result (o_result)
);
